@@ rtl/sha512_compression_core_defines.svh @@
// Assertion macros shared by the SHA-512 compression core checkers.
// No dependencies; included by the checker file.
`ifndef SHA512_COMPRESSION_CORE_DEFINES_SVH
`define SHA512_COMPRESSION_CORE_DEFINES_SVH

// Concurrent check, masked while reset is asserted.
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sha512c_pkg.sv @@
// Shared types, constants and functions of the SHA-512 compression core.
// No dependencies.
package sha512c_pkg;

  localparam int WORD_W          = 64;
  localparam int HASH_WORDS      = 8;
  localparam int BLOCK_BYTES     = 128;
  localparam int BLOCK_WORDS     = BLOCK_BYTES / 8;
  localparam int ROUNDS          = 80;
  localparam int ROUND_W         = 7;
  localparam int WCNT_W          = 4;
  localparam int IDX_W           = 3;
  localparam int CFG_IDX_W       = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  typedef struct packed {
    logic [WORD_W-1:0] message_word;
    logic              message_start;
    logic              final_block;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  digest_index;
    logic              digest_last;
  } out_t;

  // Classified request handed from front to engine
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              start;
    logic              blk_end;
    logic              final_blk;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } eng_state_t;

  function automatic logic [WORD_W-1:0] rotr64(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    rotr64 = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

@@ rtl/sha512_compression_core.sv @@
// SHA-512 compression core, top level: front, request queue and engine.
// Depends on sha512c_pkg, sha512c_front, sha512c_fifo, sha512c_engine.
//
// Usage:
//   in_*  : valid/ready channel of padded message words, sixteen per block,
//           most significant first. message_start on the first word reloads
//           the chaining value from init_word_0..7 and drops a partial block;
//           final_block on the sixteenth word requests the digest.
//   out_* : valid/ready channel of eight digest words, index 0 first,
//           digest_last on index 7.
//   cfg_* : write port for init_word_0..7 (index 0..7, others ignored);
//           write only while the core is idle.
// Throughput: the engine takes one queued word per cycle while the queue holds
// words, then runs a set-up step, the rounds (one round per cycle) and an add
// step per block, taking no new word meanwhile. A final block then reads out
// its eight digest words. The queue holds QUEUE_DEPTH words, so the sender
// keeps streaming while the round loop runs. While the receiver stalls the
// digest word holds and the engine waits; the front keeps filling the queue
// until it is full.
// Reset (synchronous) clears the queue, the chaining and init registers.
module sha512_compression_core #(
  parameter int QUEUE_DEPTH = sha512c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sha512c_pkg::in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sha512c_pkg::out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [sha512c_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sha512c_pkg::WORD_W-1:0]    cfg_wdata
);
  import sha512c_pkg::*;

  logic   push, q_full, q_valid, q_ready;
  entry_t push_data, q_data;

  sha512c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  sha512c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  sha512c_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

@@ rtl/sha512c_fifo.sv @@
// Request queue between front and engine, register based.
// Depends on sha512c_pkg (entry_t).
module sha512c_fifo #(
  parameter int DEPTH = sha512c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha512c_pkg::entry_t push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_ready,
  output sha512c_pkg::entry_t pop_data
);
  import sha512c_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/sha512c_front.sv @@
// Input front: accepts message words and tags block boundaries.
// Depends on sha512c_pkg (in_t, entry_t).
module sha512c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha512c_pkg::in_t    in_data,
  output logic                push,
  output sha512c_pkg::entry_t push_data,
  input  logic                q_full
);
  import sha512c_pkg::*;

  localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(BLOCK_WORDS - 1);

  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [WCNT_W-1:0] wcnt_eff;
  logic              blk_end;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // a start request abandons any partial block
  assign wcnt_eff = in_data.message_start ? '0 : wcnt_r;
  assign blk_end  = (wcnt_eff == LAST_WORD);

  always_comb begin
    push_data.word      = in_data.message_word;
    push_data.start     = in_data.message_start;
    push_data.blk_end   = blk_end;
    push_data.final_blk = in_data.final_block;
    wcnt_nxt            = wcnt_r;
    if (push) begin
      wcnt_nxt = blk_end ? '0 : wcnt_eff + WCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
    end else begin
      wcnt_r <= wcnt_nxt;
    end
  end

endmodule

@@ rtl/sha512c_engine.sv @@
// Compression engine: schedule window, one SHA-512 round per cycle, chaining
// value, initial-value registers and digest readout. Depends on sha512c_pkg.
module sha512c_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  sha512c_pkg::entry_t          q_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sha512c_pkg::out_t            out_data,
  input  logic                         cfg_we,
  input  logic [sha512c_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sha512c_pkg::WORD_W-1:0]    cfg_wdata
);
  import sha512c_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_RND = ROUND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(HASH_WORDS - 1);
  localparam logic [CFG_IDX_W-1:0] NUM_INIT = CFG_IDX_W'(HASH_WORDS);

  eng_state_t state_r, state_nxt;

  logic [WORD_W-1:0]  init_r  [HASH_WORDS];
  logic [WORD_W-1:0]  chain_r [HASH_WORDS];
  logic [WORD_W-1:0]  v_r     [HASH_WORDS];
  logic [WORD_W-1:0]  win_r   [BLOCK_WORDS];
  logic [WORD_W-1:0]  hkw_r;
  logic [ROUND_W-1:0] rnd_r;
  logic [IDX_W-1:0]   emit_idx_r;
  logic               final_r;

  logic               q_pop;
  logic [WORD_W-1:0]  sum1, sum0, ch, maj, t1, t2, new_w, sig0, sig1;

  assign q_pop = q_valid && q_ready;

  // round datapath; h + K + W comes pre-added from the previous cycle
  always_comb begin
    sum1  = rotr64(v_r[4], 14) ^ rotr64(v_r[4], 18) ^ rotr64(v_r[4], 41);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sum0  = rotr64(v_r[0], 28) ^ rotr64(v_r[0], 34) ^ rotr64(v_r[0], 39);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = hkw_r + sum1 + ch;
    t2    = sum0 + maj;
    sig0  = rotr64(win_r[1], 1) ^ rotr64(win_r[1], 8) ^ (win_r[1] >> 7);
    sig1  = rotr64(win_r[14], 19) ^ rotr64(win_r[14], 61) ^ (win_r[14] >> 6);
    new_w = sig1 + win_r[9] + sig0 + win_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (q_valid && q_data.blk_end) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: state_nxt = final_r ? ST_EMIT : ST_LOAD;
      ST_EMIT: begin
        if (out_ready && emit_idx_r == LAST_IDX) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD:  q_ready   = 1'b1;
      ST_EMIT:  out_valid = 1'b1;
      default: begin
        q_ready   = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_data.digest_word  = chain_r[emit_idx_r];
  assign out_data.digest_index = emit_idx_r;
  assign out_data.digest_last  = (emit_idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      emit_idx_r <= '0;
      rnd_r      <= '0;
      final_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_data.blk_end) begin
        final_r <= q_data.final_blk;
      end
      if (state_r == ST_PREP) begin
        rnd_r <= '0;
      end else if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + ROUND_W'(1);
      end
      if (state_r == ST_ADD) begin
        emit_idx_r <= '0;
      end else if (state_r == ST_EMIT && out_ready) begin
        emit_idx_r <= emit_idx_r + IDX_W'(1);
      end
    end
  end

  // init and chaining registers reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HASH_WORDS; k++) begin
        init_r[k]  <= '0;
        chain_r[k] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index < NUM_INIT) begin
        init_r[cfg_index[IDX_W-1:0]] <= cfg_wdata;
      end
      if (q_pop && q_data.start) begin
        for (int k = 0; k < HASH_WORDS; k++) begin
          chain_r[k] <= init_r[k];
        end
      end else if (state_r == ST_ADD) begin
        for (int k = 0; k < HASH_WORDS; k++) begin
          chain_r[k] <= chain_r[k] + v_r[k];
        end
      end
    end
  end

  // schedule window: win_r[0] is the word used by the current round
  always_ff @(posedge clk) begin
    if (q_pop || state_r == ST_ROUND) begin
      for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[BLOCK_WORDS-1] <= q_pop ? q_data.word : new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      for (int k = 0; k < HASH_WORDS; k++) begin
        v_r[k] <= chain_r[k];
      end
      hkw_r <= chain_r[7] + round_k('0) + win_r[0];
    end else if (state_r == ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      hkw_r  <= v_r[6] + round_k(rnd_r + ROUND_W'(1)) + win_r[1];
    end
  end

endmodule

@@ rtl/sha512c_checker.sv @@
// Port-level checks on the SHA-512 compression core, bound to the top level.
// Depends on sha512c_pkg and sha512_compression_core_defines.svh.
`include "sha512_compression_core_defines.svh"

module sha512c_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input sha512c_pkg::out_t out_data
);
  import sha512c_pkg::*;

  // a stalled digest word holds
  `SHA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "digest request changed while stalled")

  // last flag marks index seven exactly
  `SHA_ASSERT(a_last_idx, clk, rst_n, out_valid |-> (out_data.digest_last == (out_data.digest_index == IDX_W'(HASH_WORDS - 1))), "digest_last mismatch")

  // digest words leave back to back in index order
  `SHA_ASSERT(a_idx_seq, clk, rst_n, out_valid && out_ready && !out_data.digest_last |=> out_valid && out_data.digest_index == IDX_W'($past(out_data.digest_index) + IDX_W'(1)), "digest index out of order")

  // no digest straight after reset
  `SHA_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind sha512_compression_core sha512c_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
